/* rtl/acx_pkg.sv */
`default_nettype none

package acx_pkg;

    localparam int MEM_DEPTH_DEF = 256;
    localparam int ACC_WIDTH_DEF = 32;

    localparam int BYTE_W     = 8;
    localparam int OPD_RANGE  = 1 << BYTE_W;
    localparam int STATUS_W   = 3;
    localparam int OUT_ACC_W  = 32;
    localparam int S_TDATA_W  = 4 * BYTE_W;
    localparam int M_DATA_BITS = STATUS_W + OUT_ACC_W + BYTE_W;
    localparam int M_TDATA_W  = ((M_DATA_BITS + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HALT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVF   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNF   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADOP = 3'd5;

    localparam logic [BYTE_W-1:0] OP_HALT  = 8'd0;
    localparam logic [BYTE_W-1:0] OP_LOAD  = 8'd1;
    localparam logic [BYTE_W-1:0] OP_ADD   = 8'd2;
    localparam logic [BYTE_W-1:0] OP_SUB   = 8'd3;
    localparam logic [BYTE_W-1:0] OP_STA   = 8'd4;
    localparam logic [BYTE_W-1:0] OP_OUT   = 8'd5;
    localparam logic [BYTE_W-1:0] OP_CALL  = 8'd6;
    localparam logic [BYTE_W-1:0] OP_RET   = 8'd7;
    localparam logic [BYTE_W-1:0] OP_JMP   = 8'd8;
    localparam logic [BYTE_W-1:0] OP_JZ    = 8'd9;
    localparam logic [BYTE_W-1:0] OP_PUSH  = 8'd10;
    localparam logic [BYTE_W-1:0] OP_POP   = 8'd11;
    localparam logic [BYTE_W-1:0] OP_MUL   = 8'd12;

    typedef enum logic [3:0] {
        CLS_NOP,
        CLS_WRBYTE,
        CLS_LOAD,
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_STORE,
        CLS_PUSH,
        CLS_CALL,
        CLS_POP,
        CLS_RET,
        CLS_JMP,
        CLS_JZ
    } cls_t;

    typedef struct packed {
        logic                valid;
        cls_t                cls;
        logic [STATUS_W-1:0] status;
        logic                fwd;
    } stage_ctl_t;

endpackage

`default_nettype wire

/* rtl/acx_mem.sv */
`default_nettype none

module acx_mem #(
    parameter int MEM_DEPTH = acx_pkg::MEM_DEPTH_DEF,
    localparam int AW = $clog2(MEM_DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [acx_pkg::BYTE_W-1:0] rd_data,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [acx_pkg::BYTE_W-1:0] wr_data
);

    // An entry that was never written since reset reads as zero.
    logic [acx_pkg::BYTE_W-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]       valid_reg;
    logic [acx_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/acx_issue.sv */
`default_nettype none

module acx_issue #(
    parameter int MEM_DEPTH = acx_pkg::MEM_DEPTH_DEF,
    localparam int AW = $clog2(MEM_DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       kind,
    input  wire logic [acx_pkg::BYTE_W-1:0] opcode,
    input  wire logic [acx_pkg::BYTE_W-1:0] operand,
    input  wire logic [acx_pkg::BYTE_W-1:0] fall_through_pc,
    input  wire logic [acx_pkg::BYTE_W-1:0] write_data,
    input  wire logic                       ex_done,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [acx_pkg::BYTE_W-1:0] wr_data,
    output logic                            rd_en,
    output logic      [AW-1:0]              rd_addr,
    output acx_pkg::stage_ctl_t             stage_ctl,
    output logic      [AW-1:0]              stage_addr,
    output logic      [acx_pkg::BYTE_W-1:0] stage_opd,
    output logic      [acx_pkg::BYTE_W-1:0] stage_ftpc,
    output logic      [acx_pkg::BYTE_W-1:0] stage_wdata,
    output logic      [acx_pkg::BYTE_W-1:0] stage_fwd_data
);

    localparam logic [AW-1:0] SP_TOP = AW'(MEM_DEPTH - 1);

    logic [AW-1:0] addr_lut [acx_pkg::OPD_RANGE];

    for (genvar i = 0; i < acx_pkg::OPD_RANGE; i++)
    begin : g_addr_lut
        assign addr_lut[i] = AW'(i % MEM_DEPTH);
    end

    logic [AW-1:0]        sp_reg;
    logic [AW-1:0]        sp_next;
    logic                 stopped_reg;
    logic                 stopped_next;
    acx_pkg::stage_ctl_t  ctl_reg;
    acx_pkg::stage_ctl_t  ctl_next;
    logic [AW-1:0]        addr_sel;
    logic [AW-1:0]        opd_addr;
    logic                 in_fire;

    logic [AW-1:0]              addr_reg;
    logic [acx_pkg::BYTE_W-1:0] opd_reg;
    logic [acx_pkg::BYTE_W-1:0] ftpc_reg;
    logic [acx_pkg::BYTE_W-1:0] wdata_reg;
    logic [acx_pkg::BYTE_W-1:0] fwd_data_reg;

    assign in_ready = !ctl_reg.valid || ex_done;
    assign in_fire  = in_valid && in_ready;
    assign opd_addr = addr_lut[operand];

    // Stack pointer and stopped flag depend only on the word and their own values,
    // so they settle here and the next word can follow in the very next cycle.
    always_comb
    begin
        sp_next         = sp_reg;
        stopped_next    = stopped_reg;
        addr_sel        = opd_addr;
        ctl_next.valid  = 1'b1;
        ctl_next.cls    = acx_pkg::CLS_NOP;
        ctl_next.status = acx_pkg::ST_OK;
        ctl_next.fwd    = 1'b0;
        if (kind)
        begin
            ctl_next.cls = acx_pkg::CLS_WRBYTE;
        end
        else if (stopped_reg)
        begin
            ctl_next.status = acx_pkg::ST_HALT;
        end
        else
        begin
            case (opcode)
                acx_pkg::OP_HALT:
                begin
                    stopped_next    = 1'b1;
                    ctl_next.status = acx_pkg::ST_HALT;
                end
                acx_pkg::OP_LOAD:  ctl_next.cls = acx_pkg::CLS_LOAD;
                acx_pkg::OP_ADD:   ctl_next.cls = acx_pkg::CLS_ADD;
                acx_pkg::OP_SUB:   ctl_next.cls = acx_pkg::CLS_SUB;
                acx_pkg::OP_MUL:   ctl_next.cls = acx_pkg::CLS_MUL;
                acx_pkg::OP_STA:   ctl_next.cls = acx_pkg::CLS_STORE;
                acx_pkg::OP_OUT:   ctl_next.status = acx_pkg::ST_OUT;
                acx_pkg::OP_JMP:   ctl_next.cls = acx_pkg::CLS_JMP;
                acx_pkg::OP_JZ:    ctl_next.cls = acx_pkg::CLS_JZ;
                acx_pkg::OP_CALL, acx_pkg::OP_PUSH:
                begin
                    if (sp_reg == '0)
                    begin
                        stopped_next    = 1'b1;
                        ctl_next.status = acx_pkg::ST_OVF;
                    end
                    else
                    begin
                        addr_sel     = sp_reg;
                        sp_next      = sp_reg - AW'(1);
                        ctl_next.cls = (opcode == acx_pkg::OP_CALL) ?
                                       acx_pkg::CLS_CALL : acx_pkg::CLS_PUSH;
                    end
                end
                acx_pkg::OP_RET, acx_pkg::OP_POP:
                begin
                    if (sp_reg == SP_TOP)
                    begin
                        stopped_next    = 1'b1;
                        ctl_next.status = acx_pkg::ST_UNF;
                    end
                    else
                    begin
                        addr_sel     = sp_reg + AW'(1);
                        sp_next      = sp_reg + AW'(1);
                        ctl_next.cls = (opcode == acx_pkg::OP_RET) ?
                                       acx_pkg::CLS_RET : acx_pkg::CLS_POP;
                    end
                end
                default:
                begin
                    stopped_next    = 1'b1;
                    ctl_next.status = acx_pkg::ST_BADOP;
                end
            endcase
        end
        // The execute stage may be writing the entry that is read now.
        ctl_next.fwd = wr_en && (wr_addr == addr_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= SP_TOP;
            stopped_reg <= 1'b0;
            ctl_reg     <= '0;
        end
        else if (in_fire)
        begin
            sp_reg      <= sp_next;
            stopped_reg <= stopped_next;
            ctl_reg     <= ctl_next;
        end
        else if (ex_done)
        begin
            ctl_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            addr_reg     <= addr_sel;
            opd_reg      <= operand;
            ftpc_reg     <= fall_through_pc;
            wdata_reg    <= write_data;
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_en          = in_fire;
    assign rd_addr        = addr_sel;
    assign stage_ctl      = ctl_reg;
    assign stage_addr     = addr_reg;
    assign stage_opd      = opd_reg;
    assign stage_ftpc     = ftpc_reg;
    assign stage_wdata    = wdata_reg;
    assign stage_fwd_data = fwd_data_reg;

    a_stopped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("Stopped flag cleared without reset.");

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_TOP)
        else $error("Stack pointer beyond the memory.");

endmodule

`default_nettype wire

/* rtl/acx_exec.sv */
`default_nettype none

module acx_exec #(
    parameter int MEM_DEPTH = acx_pkg::MEM_DEPTH_DEF,
    parameter int ACC_WIDTH = acx_pkg::ACC_WIDTH_DEF,
    localparam int AW = $clog2(MEM_DEPTH)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire acx_pkg::stage_ctl_t          stage_ctl,
    input  wire logic [AW-1:0]                stage_addr,
    input  wire logic [acx_pkg::BYTE_W-1:0]   stage_opd,
    input  wire logic [acx_pkg::BYTE_W-1:0]   stage_ftpc,
    input  wire logic [acx_pkg::BYTE_W-1:0]   stage_wdata,
    input  wire logic [acx_pkg::BYTE_W-1:0]   stage_fwd_data,
    input  wire logic [acx_pkg::BYTE_W-1:0]   rd_data,
    output logic                              ex_done,
    output logic                              wr_en,
    output logic      [AW-1:0]                wr_addr,
    output logic      [acx_pkg::BYTE_W-1:0]   wr_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [acx_pkg::M_TDATA_W-1:0] out_data
);

    logic [ACC_WIDTH-1:0]          acc_reg;
    logic [ACC_WIDTH-1:0]          acc_next;
    logic [ACC_WIDTH+7:0]          product;
    logic [acx_pkg::BYTE_W-1:0]    mem_byte;
    logic [acx_pkg::BYTE_W-1:0]    npc;
    logic [acx_pkg::OUT_ACC_W-1:0] acc_out;
    logic                          write_cls;
    logic                          out_valid_reg;
    logic [acx_pkg::M_TDATA_W-1:0] out_data_reg;

    assign mem_byte = stage_ctl.fwd ? stage_fwd_data : rd_data;
    assign product  = acc_reg * mem_byte;
    assign ex_done  = stage_ctl.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        acc_next = acc_reg;
        npc      = stage_ftpc;
        case (stage_ctl.cls)
            acx_pkg::CLS_LOAD: acc_next = ACC_WIDTH'(mem_byte);
            acx_pkg::CLS_ADD:  acc_next = acc_reg + ACC_WIDTH'(mem_byte);
            acx_pkg::CLS_SUB:  acc_next = acc_reg - ACC_WIDTH'(mem_byte);
            acx_pkg::CLS_MUL:  acc_next = product[ACC_WIDTH-1:0];
            acx_pkg::CLS_POP:  acc_next = ACC_WIDTH'(mem_byte);
            acx_pkg::CLS_RET:  npc = mem_byte;
            acx_pkg::CLS_CALL: npc = stage_opd;
            acx_pkg::CLS_JMP:  npc = stage_opd;
            acx_pkg::CLS_JZ:
            begin
                if (acc_reg == '0)
                begin
                    npc = stage_opd;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        write_cls = stage_ctl.cls inside {acx_pkg::CLS_STORE, acx_pkg::CLS_PUSH,
                                          acx_pkg::CLS_CALL, acx_pkg::CLS_WRBYTE};
        case (stage_ctl.cls)
            acx_pkg::CLS_CALL:   wr_data = stage_ftpc;
            acx_pkg::CLS_WRBYTE: wr_data = stage_wdata;
            default:             wr_data = acc_reg[acx_pkg::BYTE_W-1:0];
        endcase
    end

    assign wr_en   = ex_done && write_cls;
    assign wr_addr = stage_addr;

    if (ACC_WIDTH >= acx_pkg::OUT_ACC_W)
    begin : g_acc_trunc
        assign acc_out = acc_next[acx_pkg::OUT_ACC_W-1:0];
    end
    else
    begin : g_acc_ext
        assign acc_out = {{(acx_pkg::OUT_ACC_W - ACC_WIDTH){1'b0}}, acc_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ex_done)
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_done)
        begin
            out_data_reg <= acx_pkg::M_TDATA_W'({npc, acc_out, stage_ctl.status});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_acc_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(acc_reg))
        else $error("Accumulator changed while the result was stalled.");

    a_write_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_ctl.valid && out_valid_reg && !out_ready) |-> !wr_en)
        else $error("Memory written by a stalled instruction.");

endmodule

`default_nettype wire

/* rtl/accumulator_cpu_execute.sv */
`default_nettype none

// Channel  Dir  tdata (low bit up)                                      tuser
// s_axis   in   opcode, operand, fall_through_pc, write_data (32 bits)   kind
// m_axis   out  status, acc_value, next_pc, zero fill (48 bits)          none
//
// One word per cycle is sustained while the output is not stalled; a word's memory
// read and issue state are registered when it is accepted, and its execute step
// then writes the result into the output register.
// The state memory has one read and one write port; a read of the entry
// being written in the same cycle is forwarded from the execute stage.
// rst_n sets the stack pointer to the top, clears flags and accumulator at once,
// and marks every memory byte unwritten so it reads as zero; no clearing pass.
// A stalled output holds the execute stage and, while it holds a word, drops s_axis_tready.

module accumulator_cpu_execute #(
    parameter int MEM_DEPTH = acx_pkg::MEM_DEPTH_DEF,
    parameter int ACC_WIDTH = acx_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // opcode, operand, fall_through_pc, write_data
    input  wire logic [acx_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // kind
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // status, acc_value, next_pc
    output logic      [acx_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int BW = acx_pkg::BYTE_W;

    acx_pkg::stage_ctl_t stage_ctl;
    logic [AW-1:0]       stage_addr;
    logic [BW-1:0]       stage_opd;
    logic [BW-1:0]       stage_ftpc;
    logic [BW-1:0]       stage_wdata;
    logic [BW-1:0]       stage_fwd_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [BW-1:0]       rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [BW-1:0]       wr_data;
    logic                ex_done;

    acx_mem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    acx_issue #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_issue (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .kind            (s_axis_tuser),
        .opcode          (s_axis_tdata[BW-1:0]),
        .operand         (s_axis_tdata[2*BW-1:BW]),
        .fall_through_pc (s_axis_tdata[3*BW-1:2*BW]),
        .write_data      (s_axis_tdata[4*BW-1:3*BW]),
        .ex_done         (ex_done),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .stage_ctl       (stage_ctl),
        .stage_addr      (stage_addr),
        .stage_opd       (stage_opd),
        .stage_ftpc      (stage_ftpc),
        .stage_wdata     (stage_wdata),
        .stage_fwd_data  (stage_fwd_data)
    );

    acx_exec #(
        .MEM_DEPTH (MEM_DEPTH),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_exec (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage_ctl      (stage_ctl),
        .stage_addr     (stage_addr),
        .stage_opd      (stage_opd),
        .stage_ftpc     (stage_ftpc),
        .stage_wdata    (stage_wdata),
        .stage_fwd_data (stage_fwd_data),
        .rd_data        (rd_data),
        .ex_done        (ex_done),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_data       (m_axis_tdata)
    );

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_ctl.valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("Input taken while the execute stage was blocked.");

endmodule

`default_nettype wire

/* tb/accumulator_cpu_execute_tb.sv */
`timescale 1ns / 1ps

module accumulator_cpu_execute_tb;
    import acx_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 10;
    localparam logic KIND_EXEC  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [31:0]         acc_value;
        logic [7:0]          next_pc;
    } exec_result_t;

    typedef enum {STOP_HALT, STOP_BADOP, STOP_UNDERFLOW, STOP_OVERFLOW} stop_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    logic [7:0]   machine_mem [256];
    logic [31:0]  machine_acc;
    logic [7:0]   machine_sp;
    logic         machine_stopped;

    exec_result_t pending_results[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;

    accumulator_cpu_execute u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("accumulator_cpu_execute verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic exec_result_t execute_word(input logic kind, input logic [7:0] op,
                                                  input logic [7:0] opd,
                                                  input logic [7:0] ftpc,
                                                  input logic [7:0] wdata);
        exec_result_t res;
        logic [7:0]   popped;
        res.status  = ST_OK;
        res.next_pc = ftpc;
        if (kind == KIND_WRITE)
            machine_mem[opd] = wdata;
        else if (machine_stopped)
            res.status = ST_HALT;
        else
        begin
            case (op)
                OP_HALT:
                begin
                    machine_stopped = 1'b1;
                    res.status = ST_HALT;
                end
                OP_LOAD:  machine_acc = {24'd0, machine_mem[opd]};
                OP_ADD:   machine_acc = machine_acc + {24'd0, machine_mem[opd]};
                OP_SUB:   machine_acc = machine_acc - {24'd0, machine_mem[opd]};
                OP_MUL:   machine_acc = machine_acc * {24'd0, machine_mem[opd]};
                OP_STA:   machine_mem[opd] = machine_acc[7:0];
                OP_OUT:   res.status = ST_OUT;
                OP_CALL, OP_PUSH:
                begin
                    if (machine_sp == 8'd0)
                    begin
                        machine_stopped = 1'b1;
                        res.status = ST_OVF;
                    end
                    else
                    begin
                        machine_mem[machine_sp] = (op == OP_CALL) ? ftpc : machine_acc[7:0];
                        machine_sp = machine_sp - 8'd1;
                        if (op == OP_CALL)
                            res.next_pc = opd;
                    end
                end
                OP_RET, OP_POP:
                begin
                    if (machine_sp == 8'hFF)
                    begin
                        machine_stopped = 1'b1;
                        res.status = ST_UNF;
                    end
                    else
                    begin
                        machine_sp = machine_sp + 8'd1;
                        popped = machine_mem[machine_sp];
                        if (op == OP_RET)
                            res.next_pc = popped;
                        else
                            machine_acc = {24'd0, popped};
                    end
                end
                OP_JMP:   res.next_pc = opd;
                OP_JZ:
                begin
                    if (machine_acc == 32'd0)
                        res.next_pc = opd;
                end
                default:
                begin
                    machine_stopped = 1'b1;
                    res.status = ST_BADOP;
                end
            endcase
        end
        res.acc_value = machine_acc;
        return res;
    endfunction

    task automatic send_word(input logic kind, input logic [7:0] op, input logic [7:0] opd,
                             input logic [7:0] ftpc, input logic [7:0] wdata);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {wdata, ftpc, opd, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(execute_word(kind, op, opd, ftpc, wdata));
    endtask

    task automatic write_byte(input logic [7:0] addr, input logic [7:0] value);
        send_word(KIND_WRITE, 8'($urandom), addr, 8'($urandom), value);
    endtask

    task automatic exec_op(input logic [7:0] op, input logic [7:0] opd);
        send_word(KIND_EXEC, op, opd, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        exec_result_t expected_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                expected_res = pending_results.pop_front();
                if (m_axis_tdata[2:0] !== expected_res.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           expected_res.status, m_axis_tdata[2:0]);
                    fail_count++;
                end
                if (m_axis_tdata[34:3] !== expected_res.acc_value)
                begin
                    $error("acc_value: expected %h, actual %h",
                           expected_res.acc_value, m_axis_tdata[34:3]);
                    fail_count++;
                end
                if (m_axis_tdata[42:35] !== expected_res.next_pc)
                begin
                    $error("next_pc: expected %h, actual %h",
                           expected_res.next_pc, m_axis_tdata[42:35]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_arithmetic();
        write_byte(8'h10, 8'hFF);
        write_byte(8'h11, 8'h01);
        write_byte(8'h00, 8'h80);
        send_word(KIND_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'h7F);
        exec_op(OP_LOAD, 8'h11);
        exec_op(OP_SUB, 8'h10);
        exec_op(OP_MUL, 8'h10);
        exec_op(OP_MUL, 8'h00);
        exec_op(OP_ADD, 8'h10);
        exec_op(OP_ADD, 8'hFF);
        exec_op(OP_STA, 8'h20);
        exec_op(OP_LOAD, 8'h20);
        send_word(KIND_EXEC, OP_OUT, 8'h00, 8'hFF, 8'h00);
    endtask

    task automatic test_control_flow();
        send_word(KIND_EXEC, OP_JMP, 8'hFF, 8'h00, 8'hFF);
        exec_op(OP_JZ, 8'h33);
        exec_op(OP_PUSH, 8'h00);
        send_word(KIND_EXEC, OP_CALL, 8'hA0, 8'h55, 8'h00);
        exec_op(OP_RET, 8'h00);
        exec_op(OP_POP, 8'h00);
        exec_op(OP_LOAD, 8'h40);
        send_word(KIND_EXEC, OP_JZ, 8'h00, 8'h12, 8'h00);
    endtask

    function automatic logic [7:0] pick_address();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, 31));
    endfunction

    task automatic test_random_program(input int tx_pct, input int rx_pct, input int n_words);
        int         sent;
        int         burst;
        int         roll;
        logic [7:0] op;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_words)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 18)
            begin
                write_byte(pick_address(), 8'($urandom));
                sent++;
            end
            else if (roll < 21)
            begin
                burst = $urandom_range(1, 48);
                while (burst > 0 && machine_sp != 8'd0 && sent < n_words)
                begin
                    exec_op($urandom_range(0, 3) == 0 ? OP_CALL : OP_PUSH, 8'($urandom));
                    burst--;
                    sent++;
                end
            end
            else
            begin
                op = 8'($urandom_range(OP_LOAD, OP_MUL));
                if ((op == OP_PUSH || op == OP_CALL) && machine_sp == 8'd0)
                    op = OP_POP;
                if ((op == OP_POP || op == OP_RET) && machine_sp == 8'hFF)
                    op = OP_PUSH;
                exec_op(op, pick_address());
                sent++;
            end
        end
        wait_for_results();
    endtask

    task automatic test_stop_conditions();
        stop_kind_t stop_kind;
        stop_kind = stop_kind_t'($urandom_range(0, 3));
        case (stop_kind)
            STOP_HALT:
                exec_op(OP_HALT, 8'($urandom));
            STOP_BADOP:
                exec_op(8'($urandom_range(OP_MUL + 1, 255)), 8'($urandom));
            STOP_UNDERFLOW:
            begin
                while (machine_sp != 8'hFF)
                    exec_op(OP_POP, 8'($urandom));
                exec_op($urandom_range(0, 1) ? OP_RET : OP_POP, 8'($urandom));
            end
            default:
            begin
                while (machine_sp != 8'd0)
                    exec_op(OP_PUSH, 8'($urandom));
                exec_op($urandom_range(0, 1) ? OP_CALL : OP_PUSH, 8'($urandom));
            end
        endcase
        write_byte(8'h05, 8'hA5);
        exec_op(OP_LOAD, 8'h05);
        repeat (30)
        begin
            if ($urandom_range(0, 2) == 0)
                write_byte(8'($urandom), 8'($urandom));
            else
                exec_op(8'($urandom), 8'($urandom));
        end
        wait_for_results();
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
            machine_mem[i] = 8'd0;
        machine_acc     = 32'd0;
        machine_sp      = 8'hFF;
        machine_stopped = 1'b0;
        tx_idle_pct     = 21;
        rx_idle_pct     = 75;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arithmetic();
        test_control_flow();
        wait_for_results();
        test_random_program(21, 75, 580);
        test_random_program(75, 21, 580);
        test_random_program(0, 0, 580);
        test_stop_conditions();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("accumulator_cpu_execute verification clean");
        else
            $display("accumulator_cpu_execute verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/acx_pkg.sv
rtl/acx_mem.sv
rtl/acx_issue.sv
rtl/acx_exec.sv
rtl/accumulator_cpu_execute.sv
tb/accumulator_cpu_execute_tb.sv
